>>> design/fsts_pkg.sv
// Shared types and constants of the fair-share task scheduler.
// Holds mode, status and datapath command codes used by all modules.
package fsts_pkg;

  localparam int unsigned TASK_BITS    = 4;
  localparam int unsigned COUNT_BITS   = TASK_BITS + 1;
  localparam int unsigned RUNTIME_BITS = 64;
  localparam int unsigned TICK_BITS    = 16;
  localparam int unsigned NICE_BITS    = 5;
  localparam int unsigned MAX_TASKS    = 1 << TASK_BITS;

  localparam logic [COUNT_BITS-1:0] LIST_DEPTH = COUNT_BITS'(MAX_TASKS);
  localparam logic [COUNT_BITS-1:0] IDLE_TASK  = COUNT_BITS'(MAX_TASKS);
  localparam logic [COUNT_BITS-1:0] NO_TASK    = COUNT_BITS'(MAX_TASKS + 1);

  localparam logic [2:0] M_ADD    = 3'd0;
  localparam logic [2:0] M_REMOVE = 3'd1;
  localparam logic [2:0] M_SLEEP  = 3'd2;
  localparam logic [2:0] M_TICK   = 3'd3;
  localparam logic [2:0] M_SCHED  = 3'd4;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_FIRST  = 3'd2;
  localparam logic [2:0] ST_SWITCH = 3'd3;
  localparam logic [2:0] ST_SAME   = 3'd4;

  localparam logic [4:0] C_NOP     = 5'd0;
  localparam logic [4:0] C_LOAD    = 5'd1;
  localparam logic [4:0] C_ADD     = 5'd2;
  localparam logic [4:0] C_RSTEP   = 5'd3;
  localparam logic [4:0] C_RDROPA  = 5'd4;
  localparam logic [4:0] C_RDROPB  = 5'd5;
  localparam logic [4:0] C_SLEEPCD = 5'd6;
  localparam logic [4:0] C_SAPPEND = 5'd7;
  localparam logic [4:0] C_CHARGE  = 5'd8;
  localparam logic [4:0] C_MINSTEP = 5'd9;
  localparam logic [4:0] C_MINEND  = 5'd10;
  localparam logic [4:0] C_SCHED   = 5'd11;
  localparam logic [4:0] C_WEXP    = 5'd12;
  localparam logic [4:0] C_SDROPA  = 5'd13;
  localparam logic [4:0] C_SDROPB  = 5'd14;
  localparam logic [4:0] C_WJOIN   = 5'd15;
  localparam logic [4:0] C_WDEC    = 5'd16;
  localparam logic [4:0] C_OUT     = 5'd17;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       idx_lt_r;
    logic       idx_lt_s;
    logic       r_match;
    logic       cd_expired;
    logic       run_valid;
  } dp_sts_t;

endpackage

>>> design/fsts_datapath.sv
// Datapath of the fair-share task scheduler: lists, per-task stores and scan logic.
// Executes one command per cycle from fsts_ctrl; depends on fsts_pkg.
module fsts_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [2:0]                           in_mode,
  input  logic [fsts_pkg::TASK_BITS-1:0]       in_task_req,
  input  logic [fsts_pkg::NICE_BITS-1:0]       in_nice,
  input  logic [fsts_pkg::TICK_BITS-1:0]       in_sleep_ticks,
  input  fsts_pkg::dp_cmd_t                    cmd,
  output fsts_pkg::dp_sts_t                    sts,
  output logic [2:0]                           out_status,
  output logic [fsts_pkg::COUNT_BITS-1:0]      out_next_task,
  output logic [fsts_pkg::RUNTIME_BITS-1:0]    out_min_vruntime
);

  logic [fsts_pkg::TASK_BITS-1:0]    rorder_r [fsts_pkg::MAX_TASKS];
  logic [fsts_pkg::TASK_BITS-1:0]    sorder_r [fsts_pkg::MAX_TASKS];
  logic [fsts_pkg::RUNTIME_BITS-1:0] rt_r     [fsts_pkg::MAX_TASKS];
  logic [fsts_pkg::NICE_BITS-1:0]    prio_r   [fsts_pkg::MAX_TASKS];
  logic [fsts_pkg::TICK_BITS-1:0]    cd_r     [fsts_pkg::MAX_TASKS];

  logic [fsts_pkg::COUNT_BITS-1:0]   rtotal_r, stotal_r, idx_r, run_r;
  logic [fsts_pkg::RUNTIME_BITS-1:0] floor_r, min_r;
  logic [fsts_pkg::TASK_BITS-1:0]    best_r, tmp_r, wake_r, task_r;
  logic [fsts_pkg::NICE_BITS-1:0]    nice_r;
  logic [fsts_pkg::TICK_BITS-1:0]    ticks_r;
  logic [2:0]                        mode_r, status_r;

  logic [fsts_pkg::COUNT_BITS-1:0]   rlast, slast, nx;
  logic [fsts_pkg::TASK_BITS-1:0]    r_ra, s_ra, r_rd, s_rd, rt_ra;
  logic [fsts_pkg::RUNTIME_BITS-1:0] rt_rd;
  logic [fsts_pkg::NICE_BITS:0]      charge;

  assign rlast  = rtotal_r - 1'b1;
  assign slast  = stotal_r - 1'b1;
  assign r_ra   = idx_r[fsts_pkg::TASK_BITS-1:0];
  assign s_ra   = idx_r[fsts_pkg::TASK_BITS-1:0];
  assign r_rd   = rorder_r[r_ra];
  assign s_rd   = sorder_r[s_ra];
  assign rt_ra  = (cmd.op == fsts_pkg::C_CHARGE) ? run_r[fsts_pkg::TASK_BITS-1:0] : r_rd;
  assign rt_rd  = rt_r[rt_ra];
  assign charge = {1'b0, prio_r[run_r[fsts_pkg::TASK_BITS-1:0]]} + 1'b1;
  assign nx     = (rtotal_r == '0) ? fsts_pkg::IDLE_TASK : {1'b0, best_r};

  assign sts.mode       = mode_r;
  assign sts.idx_lt_r   = idx_r < rtotal_r;
  assign sts.idx_lt_s   = idx_r < stotal_r;
  assign sts.r_match    = r_rd == task_r;
  assign sts.cd_expired = cd_r[s_rd] <= fsts_pkg::TICK_BITS'(1);
  assign sts.run_valid  = run_r < fsts_pkg::IDLE_TASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtotal_r <= '0;
      stotal_r <= '0;
      run_r    <= fsts_pkg::NO_TASK;
      floor_r  <= '0;
      idx_r    <= '0;
    end else begin
      case (cmd.op)
        fsts_pkg::C_LOAD: begin
          mode_r   <= in_mode;
          task_r   <= in_task_req;
          nice_r   <= in_nice;
          ticks_r  <= in_sleep_ticks;
          idx_r    <= '0;
          status_r <= fsts_pkg::ST_DONE;
        end
        fsts_pkg::C_ADD: begin
          if (rtotal_r < fsts_pkg::LIST_DEPTH) begin
            rt_r[task_r] <= floor_r;
            rorder_r[rtotal_r[fsts_pkg::TASK_BITS-1:0]] <= task_r;
            prio_r[task_r] <= nice_r;
            rtotal_r <= rtotal_r + 1'b1;
          end else begin
            status_r <= fsts_pkg::ST_FULL;
          end
        end
        fsts_pkg::C_RSTEP: idx_r <= idx_r + 1'b1;
        fsts_pkg::C_RDROPA: begin
          tmp_r    <= rorder_r[rlast[fsts_pkg::TASK_BITS-1:0]];
          rtotal_r <= rlast;
        end
        fsts_pkg::C_RDROPB: rorder_r[idx_r[fsts_pkg::TASK_BITS-1:0]] <= tmp_r;
        fsts_pkg::C_SLEEPCD: cd_r[task_r] <= ticks_r;
        fsts_pkg::C_SAPPEND: begin
          if (stotal_r < fsts_pkg::LIST_DEPTH) begin
            sorder_r[stotal_r[fsts_pkg::TASK_BITS-1:0]] <= task_r;
            stotal_r <= stotal_r + 1'b1;
          end else begin
            status_r <= fsts_pkg::ST_FULL;
          end
        end
        fsts_pkg::C_CHARGE: begin
          rt_r[rt_ra] <= rt_rd + fsts_pkg::RUNTIME_BITS'(charge);
          idx_r <= '0;
        end
        fsts_pkg::C_MINSTEP: begin
          if (idx_r == '0 || rt_rd < min_r) begin
            min_r  <= rt_rd;
            best_r <= r_rd;
          end
          idx_r <= idx_r + 1'b1;
        end
        fsts_pkg::C_MINEND: begin
          if (rtotal_r != '0) begin
            floor_r <= min_r;
          end
          idx_r <= '0;
        end
        fsts_pkg::C_SCHED: begin
          if (run_r == fsts_pkg::NO_TASK) begin
            status_r <= fsts_pkg::ST_FIRST;
          end else if (run_r == nx) begin
            status_r <= fsts_pkg::ST_SAME;
          end else begin
            status_r <= fsts_pkg::ST_SWITCH;
          end
          run_r <= nx;
        end
        fsts_pkg::C_WEXP: begin
          wake_r     <= s_rd;
          cd_r[s_rd] <= '0;
        end
        fsts_pkg::C_SDROPA: begin
          tmp_r    <= sorder_r[slast[fsts_pkg::TASK_BITS-1:0]];
          stotal_r <= slast;
        end
        fsts_pkg::C_SDROPB: sorder_r[idx_r[fsts_pkg::TASK_BITS-1:0]] <= tmp_r;
        fsts_pkg::C_WJOIN: begin
          if (rtotal_r < fsts_pkg::LIST_DEPTH) begin
            rt_r[wake_r] <= floor_r;
            rorder_r[rtotal_r[fsts_pkg::TASK_BITS-1:0]] <= wake_r;
            rtotal_r <= rtotal_r + 1'b1;
          end else begin
            status_r <= fsts_pkg::ST_FULL;
          end
        end
        fsts_pkg::C_WDEC: begin
          cd_r[s_rd] <= cd_r[s_rd] - 1'b1;
          idx_r <= idx_r + 1'b1;
        end
        fsts_pkg::C_OUT: begin
          out_status       <= status_r;
          out_next_task    <= run_r;
          out_min_vruntime <= floor_r;
        end
        default: ;
      endcase
    end
  end

  a_rtotal_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rtotal_r <= fsts_pkg::LIST_DEPTH) else $error("ready count above depth");
  a_stotal_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stotal_r <= fsts_pkg::LIST_DEPTH) else $error("sleep count above depth");
  a_sched_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == fsts_pkg::C_SCHED |=> run_r != fsts_pkg::NO_TASK)
    else $error("schedule left no task");

endmodule

>>> design/fsts_ctrl.sv
// Controller of the fair-share task scheduler: sequences list walks per item.
// Drives fsts_datapath commands and the handshakes; depends on fsts_pkg.
module fsts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fsts_pkg::dp_sts_t sts,
  output fsts_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_RFIND  = 4'd2;
  localparam logic [3:0] S_RDROPB = 4'd3;
  localparam logic [3:0] S_SAPP   = 4'd4;
  localparam logic [3:0] S_MIN    = 4'd5;
  localparam logic [3:0] S_WCHK   = 4'd6;
  localparam logic [3:0] S_WDROPA = 4'd7;
  localparam logic [3:0] S_WDROPB = 4'd8;
  localparam logic [3:0] S_WJOIN  = 4'd9;
  localparam logic [3:0] S_SMIN   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       after_drop_sleep;

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign after_drop_sleep = sts.mode == fsts_pkg::M_SLEEP;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = fsts_pkg::C_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fsts_pkg::C_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          fsts_pkg::M_ADD: begin
            cmd.op    = fsts_pkg::C_ADD;
            state_nxt = S_FIN;
          end
          fsts_pkg::M_REMOVE: state_nxt = S_RFIND;
          fsts_pkg::M_SLEEP: begin
            cmd.op    = fsts_pkg::C_SLEEPCD;
            state_nxt = S_RFIND;
          end
          fsts_pkg::M_TICK: begin
            if (sts.run_valid) begin
              cmd.op    = fsts_pkg::C_CHARGE;
              state_nxt = S_MIN;
            end else begin
              state_nxt = S_WCHK;
            end
          end
          fsts_pkg::M_SCHED: state_nxt = S_SMIN;
          default: state_nxt = S_FIN;
        endcase
      end
      S_RFIND: begin
        if (!sts.idx_lt_r) begin
          state_nxt = after_drop_sleep ? S_SAPP : S_FIN;
        end else if (sts.r_match) begin
          cmd.op    = fsts_pkg::C_RDROPA;
          state_nxt = S_RDROPB;
        end else begin
          cmd.op = fsts_pkg::C_RSTEP;
        end
      end
      S_RDROPB: begin
        cmd.op    = fsts_pkg::C_RDROPB;
        state_nxt = after_drop_sleep ? S_SAPP : S_FIN;
      end
      S_SAPP: begin
        cmd.op    = fsts_pkg::C_SAPPEND;
        state_nxt = S_FIN;
      end
      S_MIN: begin
        if (sts.idx_lt_r) begin
          cmd.op = fsts_pkg::C_MINSTEP;
        end else begin
          cmd.op    = fsts_pkg::C_MINEND;
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!sts.idx_lt_s) begin
          state_nxt = S_FIN;
        end else if (sts.cd_expired) begin
          cmd.op    = fsts_pkg::C_WEXP;
          state_nxt = S_WDROPA;
        end else begin
          cmd.op = fsts_pkg::C_WDEC;
        end
      end
      S_WDROPA: begin
        cmd.op    = fsts_pkg::C_SDROPA;
        state_nxt = S_WDROPB;
      end
      S_WDROPB: begin
        cmd.op    = fsts_pkg::C_SDROPB;
        state_nxt = S_WJOIN;
      end
      S_WJOIN: begin
        cmd.op    = fsts_pkg::C_WJOIN;
        state_nxt = S_WCHK;
      end
      S_SMIN: begin
        if (sts.idx_lt_r) begin
          cmd.op = fsts_pkg::C_MINSTEP;
        end else begin
          cmd.op    = fsts_pkg::C_SCHED;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = fsts_pkg::C_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISP) else $error("accepted item not dispatched");
  a_fin_shows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && (!out_valid_r || out_ready) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished item not presented");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r) else $error("waiting result dropped");

endmodule

>>> design/fair_share_task_scheduler_core.sv
// Fair-share task scheduler with per-task virtual runtime, sixteen task slots.
// Top level; joins fsts_ctrl and fsts_datapath, depends on fsts_pkg.
//
// One item is taken at a time and yields one result item. Remove and sleep walk
// the ready list one entry a cycle; schedule walks it for the lowest runtime; a
// tick charges the running task, if any, and walks for the minimum, then counts
// down each sleeper and moves each one that wakes to the ready list. A finished
// result waits in an output register, so the next item is taken as soon as the
// result is loaded there.
module fair_share_task_scheduler_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           in_mode,
  input  logic [fsts_pkg::TASK_BITS-1:0]       in_task_req,
  input  logic [fsts_pkg::NICE_BITS-1:0]       in_nice,
  input  logic [fsts_pkg::TICK_BITS-1:0]       in_sleep_ticks,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_status,
  output logic [fsts_pkg::COUNT_BITS-1:0]      out_next_task,
  output logic [fsts_pkg::RUNTIME_BITS-1:0]    out_min_vruntime
);

  fsts_pkg::dp_cmd_t cmd;
  fsts_pkg::dp_sts_t sts;

  fsts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsts_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_task_req      (in_task_req),
    .in_nice          (in_nice),
    .in_sleep_ticks   (in_sleep_ticks),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_next_task    (out_next_task),
    .out_min_vruntime (out_min_vruntime)
  );

endmodule

>>> sim/fsts_sched_checker.sv
// Scoreboard for the fair-share task scheduler: it watches both channels,
// predicts each result from its own copy of the lists and runtimes, and compares.
// Depends on fsts_pkg for the mode and status codes.
`timescale 1ns / 1ps

module fsts_sched_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_task_req,
  input  logic [4:0]  in_nice,
  input  logic [15:0] in_sleep_ticks,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [4:0]  out_next_task,
  input  logic [63:0] out_min_vruntime,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  next_task;
    logic [63:0] min_vrt;
  } sched_result_t;

  sched_result_t awaited_results[$];

  logic [3:0]  rdy_ids[16];
  int          ready_len;
  logic [3:0]  slp_ids[16];
  int          sleep_len;
  logic [63:0] vruntime[16];
  logic [4:0]  nice_of[16];
  logic [15:0] countdown[16];
  logic [4:0]  current_task;
  logic [63:0] min_vruntime;

  function automatic bit join_ready(logic [3:0] t);
    if (ready_len >= 16) return 0;
    vruntime[t] = min_vruntime;
    rdy_ids[ready_len] = t;
    ready_len++;
    return 1;
  endfunction

  function automatic void drop_ready(logic [3:0] t);
    for (int i = 0; i < ready_len; i++) begin
      if (rdy_ids[i] == t) begin
        ready_len--;
        rdy_ids[i] = rdy_ids[ready_len];
        return;
      end
    end
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] mode, logic [3:0] tk,
                                                  logic [4:0] nc, logic [15:0] ticks);
    sched_result_t r;
    int unsigned weight;
    logic [63:0] lowest;
    logic [3:0] best;
    logic [4:0] chosen;
    logic [3:0] t;
    int i;
    r.status = fsts_pkg::ST_DONE;
    case (mode)
      fsts_pkg::M_ADD: begin
        if (join_ready(tk)) nice_of[tk] = nc;
        else r.status = fsts_pkg::ST_FULL;
      end
      fsts_pkg::M_REMOVE: drop_ready(tk);
      fsts_pkg::M_SLEEP: begin
        countdown[tk] = ticks;
        drop_ready(tk);
        if (sleep_len < 16) begin
          slp_ids[sleep_len] = tk;
          sleep_len++;
        end else begin
          r.status = fsts_pkg::ST_FULL;
        end
      end
      fsts_pkg::M_TICK: begin
        if (current_task < 16) begin
          weight = 1024 / (int'(nice_of[current_task[3:0]]) + 1);
          vruntime[current_task[3:0]] += 64'(1024 / weight);
          if (ready_len > 0) begin
            lowest = vruntime[rdy_ids[0]];
            for (i = 1; i < ready_len; i++)
              if (vruntime[rdy_ids[i]] < lowest) lowest = vruntime[rdy_ids[i]];
            min_vruntime = lowest;
          end
        end
        i = 0;
        while (i < sleep_len) begin
          t = slp_ids[i];
          if (countdown[t] <= 1) begin
            countdown[t] = 0;
            sleep_len--;
            slp_ids[i] = slp_ids[sleep_len];
            if (!join_ready(t)) r.status = fsts_pkg::ST_FULL;
          end else begin
            countdown[t]--;
            i++;
          end
        end
      end
      fsts_pkg::M_SCHED: begin
        if (ready_len == 0) begin
          chosen = fsts_pkg::IDLE_TASK;
        end else begin
          best = rdy_ids[0];
          for (i = 1; i < ready_len; i++)
            if (vruntime[rdy_ids[i]] < vruntime[best]) best = rdy_ids[i];
          chosen = {1'b0, best};
        end
        if (current_task == fsts_pkg::NO_TASK) r.status = fsts_pkg::ST_FIRST;
        else if (current_task == chosen) r.status = fsts_pkg::ST_SAME;
        else r.status = fsts_pkg::ST_SWITCH;
        current_task = chosen;
      end
      default: ;
    endcase
    r.next_task = current_task;
    r.min_vrt = min_vruntime;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      ready_len = 0;
      sleep_len = 0;
      current_task = fsts_pkg::NO_TASK;
      min_vruntime = '0;
      awaited_results.delete();
    end else begin
      if (in_valid && in_ready)
        awaited_results.push_back(schedule_step(in_mode, in_task_req, in_nice,
                                                in_sleep_ticks));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_next_task !== want.next_task)
            report_mismatch("next_task", out_next_task, want.next_task);
          if (out_min_vruntime !== want.min_vrt)
            report_mismatch("min_vruntime", out_min_vruntime, want.min_vrt);
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> sim/fair_share_task_scheduler_core_tb.sv
// Testbench top for the fair-share task scheduler: drives directed and random
// operations under varied idling and reads the verdict from fsts_sched_checker.
// Depends on fsts_pkg, the scheduler RTL and the checker module.
`timescale 1ns / 1ps

module fair_share_task_scheduler_core_tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [3:0]  in_task_req = '0;
  logic [4:0]  in_nice = '0;
  logic [15:0] in_sleep_ticks = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_status;
  logic [4:0]  out_next_task;
  logic [63:0] out_min_vruntime;
  int          fail_count;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_request = 0;

  fair_share_task_scheduler_core dut (.*);

  fsts_sched_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #6ms;
    $display("fair_share_task_scheduler_core verification failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ready = 0;
        repeat (400) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(logic [2:0] mode, logic [3:0] tk, logic [4:0] nc,
                           logic [15:0] ticks);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1;
    in_mode = mode;
    in_task_req = tk;
    in_nice = nc;
    in_sleep_ticks = ticks;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_op();
    int pick;
    logic [15:0] ticks;
    pick = $urandom_range(99);
    ticks = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    if (pick < 25)
      send_item(fsts_pkg::M_ADD, 4'($urandom), 5'($urandom), 16'($urandom));
    else if (pick < 35)
      send_item(fsts_pkg::M_REMOVE, 4'($urandom), 5'($urandom), 16'($urandom));
    else if (pick < 50)
      send_item(fsts_pkg::M_SLEEP, 4'($urandom), 5'($urandom), ticks);
    else if (pick < 78)
      send_item(fsts_pkg::M_TICK, 4'($urandom), 5'($urandom), 16'($urandom));
    else if (pick < 96)
      send_item(fsts_pkg::M_SCHED, 4'($urandom), 5'($urandom), 16'($urandom));
    else
      send_item(3'($urandom_range(5, 7)), 4'($urandom), 5'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Every task gets a nice value first, so no wake ever lacks one.
    for (int t = 0; t < 16; t++)
      send_item(fsts_pkg::M_ADD, 4'(t), (t == 15) ? 5'd31 : 5'(t), 16'hFFFF);
    send_item(fsts_pkg::M_ADD, 4'd3, 5'd7, 16'd0);
    send_item(fsts_pkg::M_SCHED, 4'd0, 5'd0, 16'd0);
    send_item(fsts_pkg::M_TICK, 4'd0, 5'd0, 16'd0);
    send_item(fsts_pkg::M_SCHED, 4'd0, 5'd0, 16'd0);
    send_item(fsts_pkg::M_SCHED, 4'd0, 5'd0, 16'd0);
    send_item(fsts_pkg::M_REMOVE, 4'd15, 5'd0, 16'd0);
    send_item(fsts_pkg::M_SLEEP, 4'd1, 5'd0, 16'd0);
    send_item(fsts_pkg::M_SLEEP, 4'd2, 5'd31, 16'hFFFF);
    send_item(fsts_pkg::M_TICK, 4'd0, 5'd0, 16'd0);
    send_item(3'd5, 4'd0, 5'd0, 16'd0);
    send_item(3'd7, 4'd15, 5'd31, 16'hFFFF);

    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 25 : 0;
      rx_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 25 : 0;
      for (int n = 0; n < 120; n++) begin
        if (phase == 0 && n == 30) hold_request = 1;
        send_random_op();
      end
    end
    @(negedge clk);
    in_valid = 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("fair_share_task_scheduler_core verification clean");
    end else begin
      $display("fair_share_task_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/fsts_pkg.sv
design/fsts_datapath.sv
design/fsts_ctrl.sv
design/fair_share_task_scheduler_core.sv
sim/fsts_sched_checker.sv
sim/fair_share_task_scheduler_core_tb.sv
